[rtl/core/assert_macros.svh]
// Shared assertion macros for the multiset count table checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Holds at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// The given condition never occurs outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`endif

[rtl/core/mct_pkg.sv]
package mct_pkg;

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_FULL      = 2'd2;
  localparam logic [1:0] STATUS_SATURATED = 2'd3;

  localparam int unsigned KIND_W     = 2;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned OCC_W      = 16;
  localparam int unsigned TOTAL_W    = 22;
  localparam int unsigned DISTINCT_W = 7;
  localparam int unsigned STATUS_W   = 2;

  typedef struct packed {
    logic inc;
    logic dec;
    logic alloc;
  } mct_cmd_t;

endpackage

[rtl/core/mct_ifs.sv]
interface mct_req_if;
  import mct_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink (input valid, input kind, input value, output ready);
endinterface

interface mct_rsp_if;
  import mct_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  found;
  logic [OCC_W-1:0]      occurrences;
  logic [TOTAL_W-1:0]    total_elements;
  logic [DISTINCT_W-1:0] distinct_values;
  logic [STATUS_W-1:0]   status;

  modport source (output valid, output found, output occurrences, output total_elements,
                  output distinct_values, output status, input ready);
  modport sink (input valid, input found, input occurrences, input total_elements,
                input distinct_values, input status, output ready);
endinterface

[rtl/core/multiset_count_table.sv]
// A request passes the compare state (ST_MATCH) and then the update state (ST_UPDATE),
// in which its response is registered. A new request can be accepted in the update
// state of the last one; each request spends both states on the shared row of entry cells.
// A waiting response stalls the update cycle until it is taken.
// Reset (synchronous) empties the table and clears both totals.
module multiset_count_table
  import mct_pkg::*;
#(
  parameter int CAPACITY   = 64,
  parameter int COUNT_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  mct_req_if.sink    req,
  mct_rsp_if.source  rsp
);

  localparam int DIST_BITS  = $clog2(CAPACITY + 1);
  localparam int TOTAL_BITS = DIST_BITS + COUNT_BITS;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_MATCH  = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;

  logic [1:0]            state;
  logic [1:0]            state_next;
  logic [KIND_W-1:0]     kind;
  logic [VALUE_W-1:0]    key;
  logic [CAPACITY-1:0]   hit_vec;
  logic [CAPACITY-1:0]   valid_vec;
  logic [CAPACITY-1:0]   grant;
  logic [COUNT_BITS-1:0] count_arr [CAPACITY];
  logic [TOTAL_BITS-1:0] total;
  logic [TOTAL_BITS-1:0] total_next;
  logic [DIST_BITS-1:0]  distinct;
  logic [DIST_BITS-1:0]  distinct_next;

  logic                  accept;
  logic                  upd_go;
  logic                  found;
  logic                  any_free;
  logic                  at_max;
  logic                  is_add;
  logic                  is_rem;
  logic [COUNT_BITS-1:0] sel_count;
  logic [COUNT_BITS-1:0] occ;
  logic [STATUS_W-1:0]   status_next;
  mct_cmd_t              cmd;
  mct_cmd_t              cmd_live;
  logic [CAPACITY-1:0]   free_vec;

  logic [COUNT_BITS+OCC_W-1:0]      occ_wide;
  logic [TOTAL_BITS+TOTAL_W-1:0]    total_wide;
  logic [DIST_BITS+DISTINCT_W-1:0]  distinct_wide;

  assign upd_go    = (state == ST_UPDATE) && (!rsp.valid || rsp.ready);
  assign req.ready = (state == ST_IDLE) || upd_go;
  assign accept    = req.valid && req.ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_MATCH;
      end
      ST_MATCH: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (upd_go) state_next = accept ? ST_MATCH : ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind <= req.kind;
      key  <= req.value;
    end
  end

  assign free_vec = ~valid_vec;

  always_ff @(posedge clk) begin
    if (state == ST_MATCH) begin
      grant <= free_vec & (~free_vec + CAPACITY'(1));
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      mct_cell #(
        .COUNT_BITS(COUNT_BITS)
      ) u_cell (
        .clk    (clk),
        .rst    (rst),
        .cmp_en (state == ST_MATCH),
        .key    (key),
        .grant  (grant[gi]),
        .cmd    (cmd_live),
        .hit    (hit_vec[gi]),
        .valid  (valid_vec[gi]),
        .count  (count_arr[gi])
      );
    end
  endgenerate

  always_comb begin
    sel_count = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      sel_count = sel_count | (hit_vec[i] ? count_arr[i] : '0);
    end
  end

  assign found    = |hit_vec;
  assign any_free = |grant;
  assign at_max   = &sel_count;
  assign is_add   = (kind == KIND_ADD);
  assign is_rem   = (kind == KIND_REMOVE);

  always_comb begin
    cmd.inc     = is_add && found && !at_max;
    cmd.alloc   = is_add && !found && any_free;
    cmd.dec     = is_rem && found;
    status_next = STATUS_OK;
    if (is_add && found && at_max) status_next = STATUS_SATURATED;
    if (is_add && !found && !any_free) status_next = STATUS_FULL;
    if (is_rem && !found) status_next = STATUS_NOT_FOUND;

    occ           = sel_count;
    total_next    = total;
    distinct_next = distinct;
    if (cmd.inc) begin
      occ        = sel_count + COUNT_BITS'(1);
      total_next = total + TOTAL_BITS'(1);
    end
    if (cmd.alloc) begin
      occ           = COUNT_BITS'(1);
      total_next    = total + TOTAL_BITS'(1);
      distinct_next = distinct + DIST_BITS'(1);
    end
    if (cmd.dec) begin
      occ        = sel_count - COUNT_BITS'(1);
      total_next = total - TOTAL_BITS'(1);
      if (sel_count == COUNT_BITS'(1)) distinct_next = distinct - DIST_BITS'(1);
    end
  end

  always_comb begin
    cmd_live.inc   = cmd.inc && upd_go;
    cmd_live.dec   = cmd.dec && upd_go;
    cmd_live.alloc = cmd.alloc && upd_go;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total    <= '0;
      distinct <= '0;
    end else if (upd_go) begin
      total    <= total_next;
      distinct <= distinct_next;
    end
  end

  assign occ_wide      = (COUNT_BITS + OCC_W)'(occ);
  assign total_wide    = (TOTAL_BITS + TOTAL_W)'(total_next);
  assign distinct_wide = (DIST_BITS + DISTINCT_W)'(distinct_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (upd_go) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_go) begin
      rsp.found           <= found;
      rsp.occurrences     <= occ_wide[OCC_W-1:0];
      rsp.total_elements  <= total_wide[TOTAL_W-1:0];
      rsp.distinct_values <= distinct_wide[DISTINCT_W-1:0];
      rsp.status          <= status_next;
    end
  end

endmodule

[rtl/core/mct_cell.sv]
module mct_cell
  import mct_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmp_en,
  input  logic [VALUE_W-1:0]    key,
  input  logic                  grant,
  input  mct_cmd_t              cmd,
  output logic                  hit,
  output logic                  valid,
  output logic [COUNT_BITS-1:0] count
);

  logic [VALUE_W-1:0] value;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      count <= '0;
      hit   <= 1'b0;
    end else begin
      if (cmp_en) begin
        hit <= valid && (value == key);
      end
      if (cmd.alloc && grant) begin
        valid <= 1'b1;
        count <= COUNT_BITS'(1);
      end else if (cmd.inc && hit) begin
        count <= count + COUNT_BITS'(1);
      end else if (cmd.dec && hit) begin
        count <= count - COUNT_BITS'(1);
        if (count == COUNT_BITS'(1)) begin
          valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.alloc && grant) begin
      value <= key;
    end
  end

endmodule

[rtl/core/mct_checker.sv]
`include "assert_macros.svh"

module mct_checker
  import mct_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  req_valid,
  input logic                  req_ready,
  input logic                  rsp_valid,
  input logic                  rsp_ready,
  input logic                  rsp_found,
  input logic [OCC_W-1:0]      rsp_occ,
  input logic [DISTINCT_W-1:0] rsp_distinct,
  input logic [STATUS_W-1:0]   rsp_status
);

  localparam logic [DISTINCT_W-1:0] DIST_LIMIT = DISTINCT_W'(CAPACITY);

  // A pending response must stay up until it is taken.
  `ASSERT_CLK(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid)

  // The table works on one request at a time, so an accepted request blocks the next cycle.
  `ASSERT_CLK(a_one_at_a_time, clk, rst, req_valid && req_ready |=> !req_ready)

  // A refused add of a new value reports an absent value with no occurrences.
  `ASSERT_NEVER(a_full_absent, clk, rst,
                rsp_valid && (rsp_status == STATUS_FULL) && (rsp_found || (rsp_occ != '0)))

  // A saturated add always refers to a value already held.
  `ASSERT_NEVER(a_sat_found, clk, rst,
                rsp_valid && (rsp_status == STATUS_SATURATED) && !rsp_found)

  // While CAPACITY is below 128, the number of distinct values never exceeds the table size.
  `ASSERT_NEVER(a_distinct_limit, clk, rst,
                rsp_valid && (CAPACITY < 128) && (rsp_distinct > DIST_LIMIT))

endmodule

bind multiset_count_table mct_checker #(
  .CAPACITY(CAPACITY)
) u_mct_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_found    (rsp.found),
  .rsp_occ      (rsp.occurrences),
  .rsp_distinct (rsp.distinct_values),
  .rsp_status   (rsp.status)
);
